>>> hdl/evsd_pkg.sv
// Shared types and constants for the VLAN strip / EtherType demux block.
package evsd_pkg;

    typedef enum logic [1:0] {
        MODE_HEADER  = 2'd0,
        MODE_PAYLOAD = 2'd1,
        MODE_DISCARD = 2'd2
    } t_mode;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TRUNC   = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;

    localparam logic [1:0] DEST_ARP  = 2'd0;
    localparam logic [1:0] DEST_IPV4 = 2'd1;
    localparam logic [1:0] DEST_IPV6 = 2'd2;

    localparam logic [15:0] ET_VLAN_CTAG = 16'h8100;
    localparam logic [15:0] ET_VLAN_STAG = 16'h88A8;
    localparam logic [15:0] ET_ARP       = 16'h0806;
    localparam logic [15:0] ET_IPV4      = 16'h0800;
    localparam logic [15:0] ET_IPV6      = 16'h86DD;

    localparam int          TYPE_OFFSET_INIT = 12;
    localparam int          TAG_BYTES        = 4;
    localparam logic [13:0] COUNT_MAX        = 14'h3FFF;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        byte_present;
        logic [1:0]  destination;
        logic        end_of_frame;
        logic [1:0]  frame_status;
        logic [13:0] payload_count;
        logic [2:0]  tags_stripped;
    } t_result;

endpackage

>>> hdl/evsd_parse.sv
// Header parser: tag skipping, EtherType classification and result formation.
module evsd_parse #(
    parameter int MAX_TAGS        = 4,
    parameter int MAX_FRAME_BYTES = 16384
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_frame_byte,
    input  logic              i_frame_last,
    output logic              o_res_valid,
    output evsd_pkg::t_result o_res
);
    import evsd_pkg::*;

    localparam int POS_W = $clog2(MAX_FRAME_BYTES);
    localparam int OFF_W = $clog2(TYPE_OFFSET_INIT + TAG_BYTES * MAX_TAGS + 2);
    localparam int TAG_W = (MAX_TAGS > 0) ? $clog2(MAX_TAGS + 1) : 1;

    localparam logic [POS_W-1:0] POS_MAX   = POS_W'(MAX_FRAME_BYTES - 1);
    localparam logic [OFF_W-1:0] OFF_INIT  = OFF_W'(TYPE_OFFSET_INIT);
    localparam logic [OFF_W-1:0] OFF_STEP  = OFF_W'(TAG_BYTES);
    localparam logic [TAG_W-1:0] TAG_LIMIT = TAG_W'(MAX_TAGS);

    logic [POS_W-1:0] r_pos,   n_pos;
    logic [OFF_W-1:0] r_off,   n_off;
    logic [TAG_W-1:0] r_tags,  n_tags;
    logic [7:0]       r_high,  n_high;
    t_mode            r_mode,  n_mode;
    logic [1:0]       r_class, n_class;
    logic [13:0]      r_count, n_count;

    logic [POS_W-1:0] off_ext;
    logic [15:0]      ether_type;
    logic             clear;

    always_comb begin
        off_ext    = POS_W'(r_off);
        ether_type = {r_high, i_frame_byte};
        n_pos      = r_pos;
        n_off      = r_off;
        n_tags     = r_tags;
        n_high     = r_high;
        n_mode     = r_mode;
        n_class    = r_class;
        n_count    = r_count;
        clear      = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_take) begin
            unique case (r_mode)
                MODE_PAYLOAD: begin
                    if (r_count < COUNT_MAX) begin
                        n_count = r_count + 14'd1;
                    end
                    o_res_valid          = 1'b1;
                    o_res.payload_byte   = i_frame_byte;
                    o_res.byte_present   = 1'b1;
                    o_res.destination    = r_class;
                    o_res.end_of_frame   = i_frame_last;
                    o_res.frame_status   = ST_OK;
                    o_res.payload_count  = n_count;
                    clear                = i_frame_last;
                end
                MODE_HEADER: begin
                    if (r_pos < POS_MAX) begin
                        n_pos = r_pos + POS_W'(1);
                    end
                    if (r_pos == off_ext + POS_W'(1)) begin
                        if ((ether_type == ET_VLAN_CTAG || ether_type == ET_VLAN_STAG)
                                && r_tags < TAG_LIMIT) begin
                            n_tags = r_tags + TAG_W'(1);
                            n_off  = r_off + OFF_STEP;
                            if (i_frame_last) begin
                                o_res_valid        = 1'b1;
                                o_res.end_of_frame = 1'b1;
                                o_res.frame_status = ST_TRUNC;
                                clear              = 1'b1;
                            end
                        end else begin
                            priority if (ether_type == ET_ARP) begin
                                n_class = DEST_ARP;
                                n_mode  = MODE_PAYLOAD;
                            end else if (ether_type == ET_IPV4) begin
                                n_class = DEST_IPV4;
                                n_mode  = MODE_PAYLOAD;
                            end else if (ether_type == ET_IPV6) begin
                                n_class = DEST_IPV6;
                                n_mode  = MODE_PAYLOAD;
                            end else begin
                                n_mode  = MODE_DISCARD;
                            end
                            if (i_frame_last) begin
                                o_res_valid        = 1'b1;
                                o_res.end_of_frame = 1'b1;
                                if (n_mode == MODE_PAYLOAD) begin
                                    o_res.destination  = n_class;
                                    o_res.frame_status = ST_OK;
                                end else begin
                                    o_res.frame_status = ST_UNKNOWN;
                                end
                                clear = 1'b1;
                            end
                        end
                    end else begin
                        if (r_pos == off_ext) begin
                            n_high = i_frame_byte;
                        end
                        if (i_frame_last) begin
                            o_res_valid        = 1'b1;
                            o_res.end_of_frame = 1'b1;
                            o_res.frame_status = ST_TRUNC;
                            clear              = 1'b1;
                        end
                    end
                end
                default: begin
                    if (i_frame_last) begin
                        o_res_valid        = 1'b1;
                        o_res.end_of_frame = 1'b1;
                        o_res.frame_status = ST_UNKNOWN;
                        clear              = 1'b1;
                    end
                end
            endcase
            o_res.tags_stripped = 3'(n_tags);
        end

        if (clear) begin
            n_pos   = '0;
            n_off   = OFF_INIT;
            n_tags  = '0;
            n_high  = '0;
            n_mode  = MODE_HEADER;
            n_class = '0;
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_off   <= OFF_INIT;
            r_tags  <= '0;
            r_high  <= '0;
            r_mode  <= MODE_HEADER;
            r_class <= '0;
            r_count <= '0;
        end else begin
            r_pos   <= n_pos;
            r_off   <= n_off;
            r_tags  <= n_tags;
            r_high  <= n_high;
            r_mode  <= n_mode;
            r_class <= n_class;
            r_count <= n_count;
        end
    end

endmodule

>>> hdl/evsd_out_reg.sv
// Result register with valid/ready handshake toward the downstream side.
module evsd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_res_valid,
    input  evsd_pkg::t_result i_res,
    output logic              o_can_take,
    output logic              o_valid,
    input  logic              i_ready,
    output evsd_pkg::t_result o_res
);
    import evsd_pkg::*;

    logic    r_valid, n_valid;
    t_result r_res;

    assign o_can_take = !r_valid || i_ready;
    assign n_valid    = i_res_valid || (r_valid && !i_ready);
    assign o_valid    = r_valid;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

>>> hdl/eth_vlan_strip_ethertype_demux_top.sv
// A result appears in the cycle after the byte that causes it is accepted.
// Throughput: one frame byte per cycle; the parse state updates in a single pass.
// Input ready drops only while a result waits in the output register and the
// downstream side is not ready.
// Reset: synchronous active-low; clears parse state and the output valid.
module eth_vlan_strip_ethertype_demux_top #(
    parameter int MAX_TAGS        = 4,
    parameter int MAX_FRAME_BYTES = 16384
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_frame_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_payload_byte,
    output logic        o_byte_present,
    output logic [1:0]  o_destination,
    output logic        o_end_of_frame,
    output logic [1:0]  o_frame_status,
    output logic [13:0] o_payload_count,
    output logic [2:0]  o_tags_stripped
);
    import evsd_pkg::*;

    logic    take;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign take = i_in_valid && o_in_ready;

    evsd_parse #(
        .MAX_TAGS        (MAX_TAGS),
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_frame_byte (i_frame_byte),
        .i_frame_last (i_frame_last),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    evsd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_can_take  (o_in_ready),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_res       (out_res)
    );

    assign o_payload_byte  = out_res.payload_byte;
    assign o_byte_present  = out_res.byte_present;
    assign o_destination   = out_res.destination;
    assign o_end_of_frame  = out_res.end_of_frame;
    assign o_frame_status  = out_res.frame_status;
    assign o_payload_count = out_res.payload_count;
    assign o_tags_stripped = out_res.tags_stripped;

endmodule
